// File: rtl/core/sts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sts_pkg
// Shared sizes, item codes and the controller/datapath interface types for
// the sorted table search and insert core.
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
  localparam int POS_W       = 11;
  localparam int KIND_W      = 2;

  localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;     // latch the accepted item
    logic exec;        // run append, clear or search setup by kind
    logic probe_read;  // read the entry at the midpoint
    logic probe_eval;  // compare the read entry and narrow the bounds
    logic miss;        // bounds crossed: insertion position is low
    logic load_out;    // move the result into the output register
  } sts_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_search;
    logic range_empty;
    logic hit;
  } sts_stat_t;

endpackage : sts_pkg
`default_nettype wire

// File: rtl/core/sorted_table_search_insert_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_table_search_insert_core
// Sorted table with append, clear and binary search for an insertion index.
// ----------------------------------------------------------------------------
// The core works on one item at a time and gives one result per item. An
// append, a clear or an unused kind is executed in S_DISPATCH and then goes
// to S_FINISH. A search sets its bounds in S_DISPATCH and then runs P probes
// until the first hit, or until the bounds cross in S_PROBE on a miss; P is
// at most floor(log2(count)) + 1, which is 11 for a full table of 1024
// entries. Each probe is the table RAM's registered read at the midpoint in
// S_PROBE followed by the compare that narrows the bounds in S_COMPARE. The
// input is ready again in the cycle after the result is loaded, so a new item
// is taken only once the last one has left S_FINISH. A finished result sits
// in the output register, so the next item is accepted while the previous
// result has not yet been taken; its own result then waits inside the core
// until the output register is free.
// The table has no reset; only the entry count is cleared.
// ----------------------------------------------------------------------------
module sorted_table_search_insert_core
  import sts_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [KIND_W-1:0]  kind,
  input  wire logic [DATA_W-1:0]  value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic      [POS_W-1:0]   position,
  output logic                    found,
  output logic                    status
);

  sts_cmd_t  cmd;
  sts_stat_t stat;

  sts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  sts_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .kind     (kind),
    .value    (value),
    .position (position),
    .found    (found),
    .status   (status)
  );

endmodule : sorted_table_search_insert_core
`default_nettype wire

// File: rtl/core/sts_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sts_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic                                    re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : sts_ram
`default_nettype wire

// File: rtl/core/sts_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sts_datapath
// Entry table, entry count, search bounds, comparator and result registers.
// ----------------------------------------------------------------------------
module sts_datapath
  import sts_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire sts_cmd_t             cmd,
  output sts_stat_t                 stat,
  input  wire logic [KIND_W-1:0]    kind,
  input  wire logic [DATA_W-1:0]    value,
  output logic      [POS_W-1:0]     position,
  output logic                      found,
  output logic                      status
);

  logic [KIND_W-1:0]  kind_r;
  logic [DATA_W-1:0]  value_r;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] low;
  logic [COUNT_W-1:0] hi;      // exclusive upper bound
  logic [COUNT_W-1:0] mid;
  logic [COUNT_W-1:0] span;
  logic [POS_W-1:0]   res_pos;
  logic               res_found;
  logic               res_status;
  logic               full;
  logic               ram_we;
  logic [DATA_W-1:0]  rd_data;
  logic               less;
  logic               equal;

  assign full   = (count == COUNT_W'(TABLE_DEPTH));
  assign span   = hi - low;
  assign mid    = low + ((span - COUNT_W'(1)) >> 1);
  assign ram_we = cmd.exec && (kind_r == KIND_APPEND) && !full;
  assign equal  = (rd_data == value_r);
  assign less   = ($signed(rd_data) < $signed(value_r));

  assign stat.is_search   = (kind_r == KIND_SEARCH);
  assign stat.range_empty = (low >= hi);
  assign stat.hit         = equal;

  sts_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[ADDR_W-1:0]),
    .wdata (value_r),
    .re    (cmd.probe_read),
    .raddr (mid[ADDR_W-1:0]),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.exec) begin
      if (kind_r == KIND_CLEAR) begin
        count <= '0;
      end else if (ram_we) begin
        count <= count + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r  <= kind;
      value_r <= value;
    end
    if (cmd.exec) begin
      res_pos    <= '0;
      res_found  <= 1'b0;
      res_status <= (kind_r == KIND_APPEND) && full;
      if (kind_r == KIND_SEARCH) begin
        low <= '0;
        hi  <= count;
      end
    end
    if (cmd.miss) begin
      res_pos <= POS_W'(low);
    end
    if (cmd.probe_eval) begin
      if (equal) begin
        res_pos   <= POS_W'(mid);
        res_found <= 1'b1;
      end else if (less) begin
        low <= mid + COUNT_W'(1);
      end else begin
        hi <= mid;
      end
    end
    if (cmd.load_out) begin
      position <= res_pos;
      found    <= res_found;
      status   <= res_status;
    end
  end

endmodule : sts_datapath
`default_nettype wire

// File: rtl/core/sts_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sts_ctrl
// Sequencer for one item at a time: dispatch, probe loop, result handoff.
// ----------------------------------------------------------------------------
module sts_ctrl
  import sts_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  output sts_cmd_t       cmd,
  input  wire sts_stat_t stat
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_PROBE,
    S_COMPARE,
    S_FINISH
  } state_t;

  state_t state;
  logic   out_free;
  logic   out_valid_next;

  assign in_ready       = (state == S_IDLE);
  assign out_free       = !out_valid || out_ready;
  assign out_valid_next = cmd.load_out || (out_valid && !out_ready);

  always_comb begin
    cmd            = '0;
    cmd.capture    = (state == S_IDLE) && in_valid;
    cmd.exec       = (state == S_DISPATCH);
    cmd.probe_read = (state == S_PROBE) && !stat.range_empty;
    cmd.miss       = (state == S_PROBE) && stat.range_empty;
    cmd.probe_eval = (state == S_COMPARE);
    cmd.load_out   = (state == S_FINISH) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          state <= stat.is_search ? S_PROBE : S_FINISH;
        end
        S_PROBE: begin
          state <= stat.range_empty ? S_FINISH : S_COMPARE;
        end
        S_COMPARE: begin
          state <= stat.hit ? S_FINISH : S_PROBE;
        end
        S_FINISH: begin
          // The result waits here until the output register is free.
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule : sts_ctrl
`default_nettype wire

// File: rtl/core/sts_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sts_checker
// Port-level checks for the sorted table search and insert core.
// ----------------------------------------------------------------------------
module sts_checker
  import sts_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [POS_W-1:0]  position,
  input wire logic              found,
  input wire logic              status
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(position) && $stable(found)
      && $stable(status))
    else $error("result changed while stalled");

  // A dropped append never reports a search outcome.
  a_drop_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> (position == '0) && !found)
    else $error("dropped append carries search fields");

  // Only one item is in work at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while one is in work");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule : sts_checker

bind sorted_table_search_insert_core sts_checker u_sts_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .position  (position),
  .found     (found),
  .status    (status)
);
`default_nettype wire

// File: tb/table_result_checker.sv
// ----------------------------------------------------------------------------
// table_result_checker
// Watches both channels of the sorted table core, keeps its own copy of the
// table and entry count, works out the result of every accepted item and
// compares each returned result with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module table_result_checker
  import sts_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [KIND_W-1:0]  kind,
  input  logic [DATA_W-1:0]  value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [POS_W-1:0]   position,
  input  logic               found,
  input  logic               status,
  output int                 mismatches,
  output int                 outstanding
);

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             found;
    logic             status;
  } table_result_t;

  logic signed [DATA_W-1:0] entries [TABLE_DEPTH];
  int                       entry_count;
  table_result_t            awaited [$];

  // Applies one item to the shadow table and returns the result it causes.
  function automatic table_result_t predict_table_op(input logic [KIND_W-1:0] op,
                                                     input logic signed [DATA_W-1:0] operand);
    table_result_t r;
    int            lo;
    int            hi;
    int            mid;
    r = '0;
    case (op)
      KIND_APPEND: begin
        if (entry_count < TABLE_DEPTH) begin
          entries[entry_count] = operand;
          entry_count++;
        end else begin
          r.status = 1'b1;
        end
      end
      KIND_SEARCH: begin
        lo = 0;
        hi = entry_count - 1;
        while (lo <= hi && !r.found) begin
          mid = lo + (hi - lo) / 2;
          if (entries[mid] == operand) begin
            r.found    = 1'b1;
            r.position = mid[POS_W-1:0];
          end else if (entries[mid] < operand) begin
            lo = mid + 1;
          end else begin
            hi = mid - 1;
          end
        end
        if (!r.found) r.position = lo[POS_W-1:0];
      end
      KIND_CLEAR: begin
        entry_count = 0;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    table_result_t want;
    if (rst) begin
      entry_count = 0;
      awaited.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (awaited.size() == 0) begin
          $error("unexpected result: position %0d found %0b status %0b",
                 position, found, status);
          mismatches++;
        end else begin
          want = awaited.pop_front();
          if (position !== want.position) begin
            $error("position: expected %0d, actual %0d", want.position, position);
            mismatches++;
          end
          if (found !== want.found) begin
            $error("found: expected %0b, actual %0b", want.found, found);
            mismatches++;
          end
          if (status !== want.status) begin
            $error("status: expected %0b, actual %0b", want.status, status);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) awaited.push_back(predict_table_op(kind, value));
    end
    outstanding = awaited.size();
  end

endmodule : table_result_checker

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives appends, searches, clears and unused kinds into the sorted table
// core with random gaps and output stalls, and gives the final verdict from
// the mismatch count of the checker.
// ----------------------------------------------------------------------------
module testbench;
  import sts_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  logic [KIND_W-1:0] kind      = '0;
  logic [DATA_W-1:0] value     = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [POS_W-1:0]  position;
  logic              found;
  logic              status;
  int                mismatches;
  int                outstanding;

  bit                jitter = 1'b1;
  bit                quiet  = 1'b0;
  int                hold   = 0;
  int                ops_sent = 0;
  int                step;
  longint            tail;
  logic signed [DATA_W-1:0] appended [$];

  always #2 clk = ~clk;

  sorted_table_search_insert_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .position  (position),
    .found     (found),
    .status    (status)
  );

  table_result_checker monitor (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .value       (value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .position    (position),
    .found       (found),
    .status      (status),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    #4_000_000;
    $display("testbench: errors");
    $finish;
  end

  // Receiver stalls come in bursts; hold counts the low cycles still to go.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b1;
      hold      <= 0;
    end else if (hold != 0) begin
      hold      <= hold - 1;
      out_ready <= (hold == 1);
    end else if (jitter && $urandom_range(0, 5) == 0) begin
      hold      <= $urandom_range(1, 5);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send(input logic [KIND_W-1:0] k, input logic [DATA_W-1:0] v);
    if (jitter && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    value    <= v;
    do @(posedge clk); while (!in_ready);
    case (k)
      KIND_APPEND: if (appended.size() < TABLE_DEPTH) appended.push_back(v);
      KIND_CLEAR:  appended.delete();
      default: ;
    endcase
    if (k != KIND_UNUSED) ops_sent++;
  endtask

  task automatic append_sorted();
    send(KIND_APPEND, tail[DATA_W-1:0]);
    tail = tail + $urandom_range(0, step);
    if (tail > VAL_MAX) tail = VAL_MAX;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  // Search targets are mostly stored values or their neighbors so that hits
  // and near misses both occur often.
  function automatic logic [DATA_W-1:0] pick_target();
    int                       r;
    logic signed [DATA_W-1:0] pick;
    r = $urandom_range(0, 7);
    if (appended.size() == 0 || r == 0) return $urandom();
    if (r == 1) return ($urandom_range(0, 1) != 0) ? VAL_MIN : VAL_MAX;
    pick = appended[$urandom_range(0, appended.size() - 1)];
    if (r <= 4) return pick;
    if (r == 5) return pick + 1;
    return pick - 1;
  endfunction

  task automatic random_sequence();
    int n;
    int m;
    jitter = !quiet && ($urandom_range(0, 3) != 0);
    if ($urandom_range(0, 4) != 0) begin
      send(KIND_CLEAR, $urandom());
      case ($urandom_range(0, 2))
        0: begin
          tail = $urandom_range(0, 20) - 10;
          step = $urandom_range(0, 2);
        end
        1: begin
          tail = $signed($urandom()) / 2;
          step = $urandom_range(1, 1 << 20);
        end
        default: begin
          tail = longint'(VAL_MIN) + longint'($urandom_range(0, 1000));
          step = $urandom_range(1 << 22, 1 << 27);
        end
      endcase
    end
    n = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 30);
    repeat (n) begin
      if ($urandom_range(0, 24) == 0) send(KIND_APPEND, $urandom());
      else append_sorted();
      if ($urandom_range(0, 9) == 0) send(KIND_UNUSED, $urandom());
    end
    m = $urandom_range(1, 12);
    repeat (m) begin
      send(KIND_SEARCH, pick_target());
      if ($urandom_range(0, 14) == 0) send(KIND_UNUSED, $urandom());
    end
  endtask

  initial begin
    longint full_val;
    int     goal;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part: empty table, extremes, duplicates, unused kind, clear,
    // and an unsorted table.
    send(KIND_SEARCH, 32'd0);
    send(KIND_UNUSED, VAL_MAX);
    send(KIND_APPEND, VAL_MIN);
    send(KIND_APPEND, -32'sd1);
    send(KIND_APPEND, 32'd0);
    send(KIND_APPEND, 32'd0);
    send(KIND_APPEND, 32'd1);
    send(KIND_APPEND, VAL_MAX);
    send(KIND_SEARCH, VAL_MIN);
    send(KIND_SEARCH, VAL_MAX);
    send(KIND_SEARCH, 32'd0);
    send(KIND_SEARCH, -32'sd5);
    send(KIND_SEARCH, 32'd2);
    send(KIND_SEARCH, VAL_MIN + 1);
    send(KIND_UNUSED, 32'hFFFF_FFFF);
    send(KIND_CLEAR, 32'd0);
    send(KIND_SEARCH, 32'd0);
    send(KIND_APPEND, 32'd7);
    send(KIND_APPEND, 32'd3);
    send(KIND_APPEND, 32'd9);
    send(KIND_APPEND, -32'sd4);
    send(KIND_SEARCH, 32'd3);
    send(KIND_SEARCH, 32'd8);
    send(KIND_CLEAR, 32'hFFFF_FFFF);
    drain();

    // Fill the table completely, overflow it, then search the full table.
    send(KIND_CLEAR, 32'd0);
    full_val = VAL_MIN;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (i == TABLE_DEPTH - 1) full_val = VAL_MAX - 1;
      else if (i % 7 != 3) full_val = longint'(VAL_MIN) + longint'(i) * 4194304;
      send(KIND_APPEND, full_val[DATA_W-1:0]);
    end
    send(KIND_APPEND, VAL_MAX);
    send(KIND_APPEND, 32'd0);
    send(KIND_SEARCH, VAL_MAX);
    send(KIND_SEARCH, VAL_MIN);
    send(KIND_SEARCH, VAL_MAX - 1);
    repeat (16) send(KIND_SEARCH, pick_target());
    drain();

    tail = 0;
    step = 3;
    goal = ops_sent + 720;
    while (ops_sent < goal) random_sequence();

    // Closing stretch with both sides always ready.
    quiet = 1'b1;
    goal  = ops_sent + 60;
    while (ops_sent < goal) random_sequence();

    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (30) @(negedge clk);
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule : testbench
